### hw/rtl/hms_pkg.sv
// ---------------------------------------------------------------------------
// hms_pkg
// Shared types and constants for the markup stripper: channel words, the
// parse state record and its reset value.
// ---------------------------------------------------------------------------
package hms_pkg;

   typedef enum logic [2:0] {
      MODE_TEXT   = 3'd0,
      MODE_PREFIX = 3'd1,
      MODE_TAG    = 3'd2,
      MODE_CMT    = 3'd3,
      MODE_SEARCH = 3'd4,
      MODE_WAIT   = 3'd5
   } mode_type;

   // candidate bits: comment, style, script
   localparam logic [2:0] CAND_ALL = 3'b111;

   typedef struct packed {
      logic [7:0] char_in;
      logic       fragment_start;
      logic       fragment_end;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       char_valid;
      logic       end_out;
   } rsp_type;

   typedef struct packed {
      mode_type   parse_mode;
      logic [2:0] match_index;
      logic [2:0] prefix_candidates;
      logic       closing_is_script;
      logic       last_was_space;
   } state_type;

   localparam state_type STATE_RESET = '{
      parse_mode:        MODE_TEXT,
      match_index:       3'd0,
      prefix_candidates: CAND_ALL,
      closing_is_script: 1'b0,
      last_was_space:    1'b0
   };

endpackage

### hw/rtl/hms_parser.sv
// ---------------------------------------------------------------------------
// hms_parser
// Next-state and output logic for one byte: tag prefix matching, comment
// and closing-tag search, whitespace collapsing.
// ---------------------------------------------------------------------------
module hms_parser
   import hms_pkg::*;
(
   input  state_type state_cur,
   input  req_type   item,
   output state_type state_nxt,
   output rsp_type   rsp
);

   function automatic logic [7:0] lower_byte(input logic [7:0] c);
      lower_byte = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
   endfunction

   function automatic logic is_text_space(input logic [7:0] c);
      is_text_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
   endfunction

   function automatic logic is_tag_space(input logic [7:0] c);
      is_tag_space = (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0d);
   endfunction

   function automatic logic [7:0] cmt_char(input logic [2:0] k);
      unique case (k)
         3'd0:    cmt_char = 8'h21;   // !
         3'd1:    cmt_char = 8'h2d;   // -
         3'd2:    cmt_char = 8'h2d;
         default: cmt_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] style_char(input logic [2:0] k);
      unique case (k)
         3'd0:    style_char = 8'h73;   // s
         3'd1:    style_char = 8'h74;   // t
         3'd2:    style_char = 8'h79;   // y
         3'd3:    style_char = 8'h6c;   // l
         3'd4:    style_char = 8'h65;   // e
         default: style_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] script_char(input logic [2:0] k);
      unique case (k)
         3'd0:    script_char = 8'h73;   // s
         3'd1:    script_char = 8'h63;   // c
         3'd2:    script_char = 8'h72;   // r
         3'd3:    script_char = 8'h69;   // i
         3'd4:    script_char = 8'h70;   // p
         3'd5:    script_char = 8'h74;   // t
         default: script_char = 8'h00;
      endcase
   endfunction

   // closing tag is "</" followed by the opening name
   function automatic logic [7:0] close_char(input logic [2:0] k, input logic script);
      if (k == 3'd0) begin
         close_char = 8'h3c;
      end else if (k == 3'd1) begin
         close_char = 8'h2f;
      end else if (script) begin
         close_char = script_char(k - 3'd2);
      end else begin
         close_char = style_char(k - 3'd2);
      end
   endfunction

   function automatic state_type clear_parse(input state_type s);
      clear_parse                   = STATE_RESET;
      clear_parse.last_was_space    = s.last_was_space;
   endfunction

   state_type  s;
   state_type  nxt;
   logic [7:0] c;
   logic [7:0] lc;
   logic [2:0] k;
   logic [2:0] cand;
   logic [7:0] oc;
   logic       ov;
   logic       close_last;

   always_comb begin
      s          = item.fragment_start ? STATE_RESET : state_cur;
      nxt        = s;
      c          = item.char_in;
      lc         = lower_byte(item.char_in);
      k          = s.match_index;
      cand       = s.prefix_candidates;
      oc         = 8'h00;
      ov         = 1'b0;
      close_last = s.closing_is_script ? (k == 3'd7) : (k == 3'd6);

      unique case (s.parse_mode)
         MODE_TEXT: begin
            if (c == 8'h3c) begin
               nxt.parse_mode        = MODE_PREFIX;
               nxt.match_index       = 3'd0;
               nxt.prefix_candidates = CAND_ALL;
            end else if (is_text_space(c)) begin
               if (!s.last_was_space) begin
                  nxt.last_was_space = 1'b1;
                  oc                 = 8'h20;
                  ov                 = 1'b1;
               end
            end else begin
               oc                 = c;
               ov                 = 1'b1;
               nxt.last_was_space = 1'b0;
            end
         end
         MODE_PREFIX: begin
            // leading whitespace after the opening bracket is skipped
            if (!(k == 3'd0 && is_tag_space(c))) begin
               if (cand[0] && !(k < 3'd3 && cmt_char(k) == c)) begin
                  cand[0] = 1'b0;
               end
               if (cand[1] && !(k < 3'd5 && style_char(k) == lc)) begin
                  cand[1] = 1'b0;
               end
               if (cand[2] && !(k < 3'd6 && script_char(k) == lc)) begin
                  cand[2] = 1'b0;
               end
               nxt.prefix_candidates = cand;
               priority if (cand[0] && k == 3'd2) begin
                  nxt.parse_mode  = MODE_CMT;
                  nxt.match_index = 3'd0;
               end else if (cand[1] && k == 3'd4) begin
                  nxt.parse_mode        = MODE_SEARCH;
                  nxt.closing_is_script = 1'b0;
                  nxt.match_index       = 3'd0;
               end else if (cand[2] && k == 3'd5) begin
                  nxt.parse_mode        = MODE_SEARCH;
                  nxt.closing_is_script = 1'b1;
                  nxt.match_index       = 3'd0;
               end else if (cand == 3'b000) begin
                  nxt.parse_mode  = (c == 8'h3e) ? MODE_TEXT : MODE_TAG;
                  nxt.match_index = 3'd0;
               end else begin
                  nxt.match_index = k + 3'd1;
               end
            end
         end
         MODE_TAG, MODE_WAIT: begin
            if (c == 8'h3e) begin
               nxt = clear_parse(s);
            end
         end
         MODE_CMT: begin
            if (c == 8'h2d) begin
               if (k < 3'd2) begin
                  nxt.match_index = k + 3'd1;
               end
            end else if (c == 8'h3e && k >= 3'd2) begin
               nxt = clear_parse(s);
            end else begin
               nxt.match_index = 3'd0;
            end
         end
         MODE_SEARCH: begin
            if (lc == close_char(k, s.closing_is_script)) begin
               if (close_last) begin
                  nxt.parse_mode  = MODE_WAIT;
                  nxt.match_index = 3'd0;
               end else begin
                  nxt.match_index = k + 3'd1;
               end
            end else begin
               // a fresh bracket may begin the closing tag again
               nxt.match_index = (c == 8'h3c) ? 3'd1 : 3'd0;
            end
         end
         default: begin
            nxt = clear_parse(s);
         end
      endcase

      if (item.fragment_end) begin
         nxt = STATE_RESET;
      end
   end

   assign state_nxt      = nxt;
   assign rsp.char_out   = oc;
   assign rsp.char_valid = ov;
   assign rsp.end_out    = item.fragment_end;

endmodule

### hw/rtl/html_markup_stripper.sv
// ---------------------------------------------------------------------------
// html_markup_stripper
// Streaming markup remover: one byte in, one result word out per byte.
//
// The req_ channel takes one byte of text with fragment start and end flags.
// Every accepted byte yields exactly one rsp_ word: the kept byte with
// char_valid set, or char_valid clear when the byte was markup or a
// repeated blank, plus an echo of the fragment end flag.
// A byte sits in the input register, is parsed on its way to the
// result register, and appears on rsp_valid once that register loads.
// The parse state is a handful of flops updated once per byte through a
// short compare network, so one byte is taken every cycle while rsp_stall is low.
// When rsp_stall is high the result word holds and the input register
// still fills once; req_stall then rises until the result is taken.
// Synchronous reset empties both registers and returns the parser to plain
// text with no pending blank; a fragment boundary does the same for the
// parse state.
// ---------------------------------------------------------------------------
module html_markup_stripper
   import hms_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic      in_vld_ff;
   logic      in_vld_in;
   req_type   in_data_ff;
   logic      out_vld_ff;
   logic      out_vld_in;
   rsp_type   out_data_ff;
   state_type state_ff;
   state_type state_in;
   rsp_type   rsp_calc;
   logic      out_load;
   logic      advance;
   logic      req_take;

   hms_parser u_parser (
      .state_cur (state_ff),
      .item      (in_data_ff),
      .state_nxt (state_in),
      .rsp       (rsp_calc)
   );

   assign out_load  = !out_vld_ff || !rsp_stall;
   assign advance   = in_vld_ff && out_load;
   assign req_stall = in_vld_ff && !out_load;
   assign req_take  = req_valid && !req_stall;

   assign in_vld_in  = req_take || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         state_ff   <= STATE_RESET;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= rsp_calc;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

   a_drop_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.char_valid |-> rsp_data.char_out == 8'h00)
      else $error("dropped word carries a byte");

   a_frag_end_clears: assert property (@(posedge clock) disable iff (reset)
      advance && in_data_ff.fragment_end |=> state_ff == STATE_RESET)
      else $error("state not cleared after fragment end");

   a_text_index: assert property (@(posedge clock) disable iff (reset)
      state_ff.parse_mode == MODE_TEXT |-> state_ff.match_index == 3'd0)
      else $error("match index left over in plain text");

   a_cmt_dashes: assert property (@(posedge clock) disable iff (reset)
      state_ff.parse_mode == MODE_CMT |-> state_ff.match_index <= 3'd2)
      else $error("comment dash count out of range");

   a_prefix_cand: assert property (@(posedge clock) disable iff (reset)
      state_ff.parse_mode == MODE_PREFIX |-> state_ff.prefix_candidates != 3'b000)
      else $error("prefix mode with no candidate left");

   a_advance_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("parsed byte lost before result register");

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the markup stripper byte by byte. A short directed run covers
// comments, hidden style blocks, blanks and cut-off tags. It is followed by
// random fragments built mostly from well-formed markup with random content.
// Each accepted byte is run through a local parser model, and every result
// word is compared with the oldest prediction. Both sides idle at random, and
// the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import hms_pkg::*;

   localparam int RUN_LIMIT = 200_000;

   localparam logic [0:2][7:0] OPEN_CMT     = "!--";
   localparam logic [0:4][7:0] OPEN_STYLE   = "style";
   localparam logic [0:5][7:0] OPEN_SCRIPT  = "script";
   localparam logic [0:6][7:0] CLOSE_STYLE  = "</style";
   localparam logic [0:7][7:0] CLOSE_SCRIPT = "</script";

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // parser model state
   mode_type   pmode = MODE_TEXT;
   logic [2:0] pos = '0;
   logic [2:0] cands = CAND_ALL;
   logic       want_script = 1'b0;
   logic       after_space = 1'b0;

   req_type    text_q[$];
   rsp_type    cleaned_q[$];
   logic [7:0] frag_q[$];
   rsp_type    oldest;

   int words_sent = 0;
   int words_got = 0;
   int send_gap = 0;
   int stall_gap = 0;
   int hold_left = 0;
   int fail_count = 0;
   int cycle_count = 0;

   html_markup_stripper DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic void clear_parse();
      pmode       = MODE_TEXT;
      pos         = '0;
      cands       = CAND_ALL;
      want_script = 1'b0;
   endfunction

   function automatic rsp_type strip_byte(req_type w);
      rsp_type    r;
      logic [7:0] c;
      logic [7:0] lc;
      logic [7:0] tgt;
      logic [2:0] k;
      logic [2:0] cand;
      c  = w.char_in;
      lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      r  = '0;
      if (w.fragment_start) begin
         clear_parse();
         after_space = 1'b0;
      end
      case (pmode)
         MODE_TEXT: begin
            if (c == "<") begin
               pmode = MODE_PREFIX;
               pos   = '0;
               cands = CAND_ALL;
            end else if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
               if (!after_space) begin
                  after_space  = 1'b1;
                  r.char_out   = " ";
                  r.char_valid = 1'b1;
               end
            end else begin
               r.char_out   = c;
               r.char_valid = 1'b1;
               after_space  = 1'b0;
            end
         end
         MODE_PREFIX: begin
            k    = pos;
            cand = cands;
            // blanks straight after the '<' are skipped
            if (!(k == 0 && (c == " " || c == 8'd9 || c == 8'd10 || c == 8'd13))) begin
               if (cand[0] && !(k < 3 && OPEN_CMT[k] == c)) cand[0] = 1'b0;
               if (cand[1] && !(k < 5 && OPEN_STYLE[k] == lc)) cand[1] = 1'b0;
               if (cand[2] && !(k < 6 && OPEN_SCRIPT[k] == lc)) cand[2] = 1'b0;
               cands = cand;
               if (cand[0] && k == 3'd2) begin
                  pmode = MODE_CMT;
                  pos   = '0;
               end else if (cand[1] && k == 3'd4) begin
                  pmode       = MODE_SEARCH;
                  want_script = 1'b0;
                  pos         = '0;
               end else if (cand[2] && k == 3'd5) begin
                  pmode       = MODE_SEARCH;
                  want_script = 1'b1;
                  pos         = '0;
               end else if (cand == 3'b000) begin
                  pmode = (c == ">") ? MODE_TEXT : MODE_TAG;
                  pos   = '0;
               end else begin
                  pos = k + 3'd1;
               end
            end
         end
         MODE_TAG, MODE_WAIT: begin
            if (c == ">") clear_parse();
         end
         MODE_CMT: begin
            if (c == "-") begin
               if (pos < 3'd2) pos = pos + 3'd1;
            end else if (c == ">" && pos >= 3'd2) begin
               clear_parse();
            end else begin
               pos = '0;
            end
         end
         MODE_SEARCH: begin
            k   = pos;
            tgt = want_script ? CLOSE_SCRIPT[k] : CLOSE_STYLE[k];
            if (lc == tgt) begin
               if (k == (want_script ? 3'd7 : 3'd6)) begin
                  pmode = MODE_WAIT;
                  pos   = '0;
               end else begin
                  pos = k + 3'd1;
               end
            end else begin
               // a stray '<' may itself start the closing tag
               pos = (c == "<") ? 3'd1 : 3'd0;
            end
         end
         default: clear_parse();
      endcase
      if (w.fragment_end) begin
         clear_parse();
         after_space = 1'b0;
      end
      r.end_out = w.fragment_end;
      return r;
   endfunction

   function automatic logic [7:0] pick(string set);
      return set[$urandom_range(0, set.len() - 1)];
   endfunction

   task automatic add_char(logic [7:0] c);
      frag_q = {frag_q, c};
   endtask

   task automatic put(string s, bit fold);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (fold && c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
         add_char(c);
      end
   endtask

   task automatic add_piece();
      string name;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            repeat ($urandom_range(1, 6)) begin
               case ($urandom_range(0, 4))
                  0: add_char(" ");
                  1: add_char(8'($urandom_range(9, 13)));
                  2: add_char(8'($urandom_range(0, 255)));
                  default: add_char(pick("aBz09.,;"));
               endcase
            end
         end
         3: begin
            put("<", 0);
            repeat ($urandom_range(0, 2)) add_char(pick(" \t\n\r"));
            repeat ($urandom_range(1, 4)) add_char(pick("abpsSiT/"));
            if ($urandom_range(0, 1)) put(" x=\"1\"", 0);
            put(">", 0);
         end
         4: begin
            put("<!--", 0);
            repeat ($urandom_range(0, 6)) add_char(pick("-->a <"));
            put("-->", 0);
         end
         5, 6: begin
            name = $urandom_range(0, 1) ? "style" : "script";
            put("<", 0);
            repeat ($urandom_range(0, 2)) add_char(pick(" \t\n\r"));
            put(name, 1);
            repeat ($urandom_range(0, 3)) add_char(pick(" a=>\""));
            repeat ($urandom_range(0, 6)) add_char(pick("<</stylecrip>T x"));
            if ($urandom_range(0, 1)) put({"</", name.substr(0, 2)}, 1);
            put({"</", name}, 1);
            repeat ($urandom_range(0, 2)) add_char(pick(" a\t"));
            put(">", 0);
         end
         7: begin
            // prefix that breaks off before it is complete
            case ($urandom_range(0, 2))
               0: name = "!--";
               1: name = "style";
               default: name = "script";
            endcase
            put("<", 0);
            repeat ($urandom_range(0, 1)) add_char(pick(" \t\n\r"));
            put(name.substr(0, $urandom_range(0, name.len() - 2)), 1);
            add_char(pick(" \t>xq-<"));
            if ($urandom_range(0, 1)) put(">", 0);
         end
         8: repeat ($urandom_range(1, 4)) add_char(8'($urandom_range(0, 255)));
         default: add_char(pick("<>"));
      endcase
   endtask

   task automatic emit_fragment(bit opened, bit closed);
      req_type w;
      for (int i = 0; i < frag_q.size(); i++) begin
         w.char_in        = frag_q[i];
         w.fragment_start = (opened && i == 0) || ($urandom_range(0, 99) == 0);
         w.fragment_end   = (closed && i == frag_q.size() - 1) || ($urandom_range(0, 99) == 0);
         text_q = {text_q, w};
      end
      frag_q = {};
   endtask

   task automatic check_field(string field, logic [7:0] want, logic [7:0] seen);
      if (want !== seen) begin
         fail_count++;
         if (fail_count <= 10)
            $display("mismatch on %s at word %0d: expected %h, got %h",
                     field, words_got, want, seen);
      end
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            cleaned_q = {cleaned_q, strip_byte(req_data)};
            words_sent++;
            send_gap = ((words_sent % 160) < 40) ? 0 : $urandom_range(0, 4);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (text_q.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= text_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (cleaned_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("result word %h with nothing pending", rsp_data);
            end else begin
               oldest = cleaned_q.pop_front();
               check_field("char_out", oldest.char_out, rsp_data.char_out);
               check_field("char_valid", 8'(oldest.char_valid), 8'(rsp_data.char_valid));
               check_field("end_out", 8'(oldest.end_out), 8'(rsp_data.end_out));
            end
            words_got++;
            // one long hold-off so the block backs up into its input
            if (words_got == 250) hold_left = 60;
            stall_gap = ((words_got % 130) < 35) ? 0 : $urandom_range(0, 4);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_gap > 0) begin
            stall_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int total;
      int cut;
      // comment whose opening dashes must not close it, then a top-bit byte
      put("<!-->-->", 0);
      add_char(8'hFF);
      emit_fragment(1, 1);
      // blank after '<', '>' ending the prefix, blank runs, zero byte,
      // blank inside a prefix and a tag left open at the fragment end
      put("< >", 0);
      add_char(8'h09);
      add_char(8'h0A);
      add_char(8'h00);
      put("<s b", 0);
      emit_fragment(1, 1);
      put("<STYLE></style>", 0);
      emit_fragment(1, 0);

      while (text_q.size() < 535) begin
         repeat ($urandom_range(1, 6)) add_piece();
         if ($urandom_range(0, 5) == 0) begin
            cut = $urandom_range(1, frag_q.size());
            while (frag_q.size() > cut) void'(frag_q.pop_back());
         end
         emit_fragment($urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
      end
      total = text_q.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (words_sent < total) @(negedge clock);
      while (cleaned_q.size() != 0) @(negedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
